/* src/bstb_pkg.sv */
// Shared types, constants, lookup tables and arithmetic helpers for the texel blend unit.
`default_nettype none
package bstb_pkg;

   localparam int WEIGHT_BITS_DEFAULT = 8;
   localparam int MAX_WEIGHT_BITS     = 16;
   localparam int WGT_W               = MAX_WEIGHT_BITS + 1;
   localparam int LIN_W               = 17;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam logic [LIN_W-1:0] ONE_Q16 = 17'h10000;

   typedef logic [255:0][LIN_W-1:0] lin_table_type;

   typedef enum logic [1:0] {
      CSR_TINT_RED   = 2'd0,
      CSR_TINT_GREEN = 2'd1,
      CSR_TINT_BLUE  = 2'd2,
      CSR_TINT_ALPHA = 2'd3
   } csr_index_type;

   // lin[texel][channel]: texel a,b,c,d = 0..3; channel b,g,r,a = 0..3
   typedef struct packed {
      logic [3:0][3:0][LIN_W-1:0] lin;
      logic [3:0][LIN_W-1:0]      dlin;
      logic [WGT_W-1:0]           weight_x;
      logic [WGT_W-1:0]           weight_y;
   } item_type;

   // (c*c*65536 + 32512) / 65025
   function automatic lin_table_type build_lin_rgb();
      lin_table_type t;
      longint        c;
      for (int i = 0; i < 256; i++) begin
         c = longint'(i);
         t[i] = LIN_W'((c * c * 64'sd65536 + 64'sd32512) / 64'sd65025);
      end
      return t;
   endfunction

   // (a*65536 + 127) / 255
   function automatic lin_table_type build_lin_a();
      lin_table_type t;
      longint        a;
      for (int i = 0; i < 256; i++) begin
         a = longint'(i);
         t[i] = LIN_W'((a * 64'sd65536 + 64'sd127) / 64'sd255);
      end
      return t;
   endfunction

   // smallest linear value that encodes to n: ceil((2n-1)^2*65536/260100)
   function automatic lin_table_type build_srgb_thresh();
      lin_table_type t;
      longint        o;
      t[0] = '0;
      for (int i = 1; i < 256; i++) begin
         o = longint'(2 * i - 1);
         t[i] = LIN_W'((o * o * 64'sd65536 + 64'sd260099) / 64'sd260100);
      end
      return t;
   endfunction

   localparam lin_table_type LIN_RGB_TABLE = build_lin_rgb();
   localparam lin_table_type LIN_A_TABLE   = build_lin_a();
   localparam lin_table_type SRGB_THRESH   = build_srgb_thresh();

   // floor(x/255) by a shift series, then one correction step
   function automatic logic [33:0] div255(input logic [33:0] x);
      logic [34:0] s;
      logic [34:0] q;
      logic [34:0] r;
      s = 35'(x) + 35'(x >> 8) + 35'(x >> 16) + 35'(x >> 24) + 35'(x >> 32);
      q = s >> 8;
      r = 35'(x) - ((q << 8) - q);
      if (r >= 35'd255) begin
         q = q + 35'd1;
      end
      return q[33:0];
   endfunction

   function automatic logic [LIN_W-1:0] sat1(input logic [33:0] v);
      return (v > 34'(ONE_Q16)) ? ONE_Q16 : v[LIN_W-1:0];
   endfunction

endpackage
`default_nettype wire

/* src/bstb_front.sv */
// Input side: weight clamping and per-channel linearization of texels and destination.
`default_nettype none
module bstb_front #(
   parameter int WEIGHT_BITS = bstb_pkg::WEIGHT_BITS_DEFAULT
) (
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [31:0]       req_texel_a,
   input  wire logic [31:0]       req_texel_b,
   input  wire logic [31:0]       req_texel_c,
   input  wire logic [31:0]       req_texel_d,
   input  wire logic [8:0]        req_weight_x,
   input  wire logic [8:0]        req_weight_y,
   input  wire logic [31:0]       req_dest_pixel,
   input  wire logic              queue_full,
   output logic                   push,
   output bstb_pkg::item_type     push_item
);

   localparam logic [31:0] W_ONE = 32'd1 << WEIGHT_BITS;

   logic [3:0][31:0] tex;

   assign tex       = {req_texel_d, req_texel_c, req_texel_b, req_texel_a};
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_item.weight_x = (32'(req_weight_x) > W_ONE) ? bstb_pkg::WGT_W'(W_ONE)
                                                       : bstb_pkg::WGT_W'(req_weight_x);
      push_item.weight_y = (32'(req_weight_y) > W_ONE) ? bstb_pkg::WGT_W'(W_ONE)
                                                       : bstb_pkg::WGT_W'(req_weight_y);
      for (int t = 0; t < 4; t++) begin
         for (int k = 0; k < 3; k++) begin
            push_item.lin[t][k] = bstb_pkg::LIN_RGB_TABLE[tex[t][8*k +: 8]];
         end
         push_item.lin[t][3] = bstb_pkg::LIN_A_TABLE[tex[t][31:24]];
      end
      for (int k = 0; k < 3; k++) begin
         push_item.dlin[k] = bstb_pkg::LIN_RGB_TABLE[req_dest_pixel[8*k +: 8]];
      end
      push_item.dlin[3] = bstb_pkg::LIN_A_TABLE[req_dest_pixel[31:24]];
   end

endmodule
`default_nettype wire

/* src/bstb_queue.sv */
// Small FIFO between the input side and the blend pipeline.
`default_nettype none
module bstb_queue #(
   parameter int DEPTH = bstb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire bstb_pkg::item_type push_item,
   input  wire logic               pop,
   output bstb_pkg::item_type      head_item,
   output logic                    head_valid,
   output logic                    full
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

   bstb_pkg::item_type store_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign head_item  = store_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == CW'(DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH)) else $error("queue count past depth");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + CW'(1))
      else $error("queue count did not follow push");
`endif

endmodule
`default_nettype wire

/* src/bstb_back.sv */
// Blend pipeline: bilinear filter, tint, premultiplied over, and re-encode.
`default_nettype none
module bstb_back #(
   parameter int WEIGHT_BITS = bstb_pkg::WEIGHT_BITS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire bstb_pkg::item_type head_item,
   input  wire logic               head_valid,
   output logic                    head_pop,
   input  wire logic [3:0][7:0]    tint,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [31:0]             rsp_blended_pixel
);

   localparam int WW    = WEIGHT_BITS + 1;
   localparam int ROW_W = bstb_pkg::LIN_W + WW;
   localparam int TEX_W = ROW_W + WW + 1;
   localparam int LW    = bstb_pkg::LIN_W;
   localparam logic [WW-1:0]    W_ONE = WW'(1) << WEIGHT_BITS;
   localparam logic [TEX_W-1:0] HALF  = TEX_W'(1) << (2 * WEIGHT_BITS - 1);

   logic       en;
   logic [8:0] vld_ff;

   // stage 1: rows
   logic [3:0][ROW_W-1:0] top_ff, top_in, bot_ff, bot_in;
   logic [WW-1:0]         wy_ff;
   logic [3:0][LW-1:0]    d1_ff;
   logic [WW-1:0]         wx, wxn, wyn;
   // stage 2: filtered texel
   logic [3:0][LW-1:0]    tex_ff, tex_in, d2_ff;
   // stage 3: tint products
   logic [2:0][15:0]      tt_ff;
   logic [24:0]           pa_ff;
   logic [2:0][32:0]      px_ff;
   logic [3:0][LW-1:0]    d3_ff;
   // stage 4
   logic [LW-1:0]         sa_ff, sa_in;
   logic [2:0][26:0]      q1_ff, q1_in;
   logic [3:0][LW-1:0]    d4_ff;
   // stage 5
   logic [3:0][LW-1:0]    src_ff, src_in, d5_ff;
   logic [LW-1:0]         inv_ff;
   // stage 6
   logic [3:0][33:0]      prod_ff;
   logic [3:0][LW-1:0]    src6_ff;
   // stage 7
   logic [3:0][LW-1:0]    o_ff, o_in;
   // stage 8
   logic [2:0][7:0]       nhi_ff, nhi_in;
   logic [2:0][LW-1:0]    o8_ff;
   logic [7:0]            a8_ff, a8_in;
   logic [24:0]           a_scaled;
   // stage 9
   logic [2:0][7:0]       n_in;
   logic [31:0]           pixel_ff;

   assign en        = !vld_ff[8] || !rsp_stall;
   assign head_pop  = en && head_valid;
   assign rsp_valid = vld_ff[8];
   assign rsp_blended_pixel = pixel_ff;

   assign wx  = head_item.weight_x[WW-1:0];
   assign wxn = W_ONE - wx;
   assign wyn = W_ONE - wy_ff;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         top_in[k] = ROW_W'(head_item.lin[0][k]) * ROW_W'(wxn)
                   + ROW_W'(head_item.lin[1][k]) * ROW_W'(wx);
         bot_in[k] = ROW_W'(head_item.lin[2][k]) * ROW_W'(wxn)
                   + ROW_W'(head_item.lin[3][k]) * ROW_W'(wx);
         tex_in[k] = LW'((TEX_W'(top_ff[k]) * TEX_W'(wyn)
                        + TEX_W'(bot_ff[k]) * TEX_W'(wy_ff) + HALF) >> (2 * WEIGHT_BITS));
         o_in[k]   = bstb_pkg::sat1(((prod_ff[k] + 34'd32768) >> 16) + 34'(src6_ff[k]));
      end
      sa_in = bstb_pkg::sat1(bstb_pkg::div255(34'(pa_ff) + 34'd127));
      for (int k = 0; k < 3; k++) begin
         q1_in[k]  = 27'(bstb_pkg::div255(34'(px_ff[k]) + 34'd32512));
         src_in[k] = bstb_pkg::sat1(bstb_pkg::div255(34'(q1_ff[k])));
      end
      src_in[3] = sa_ff;
   end

   // 255*a rounded back to eight bits
   assign a_scaled = (25'(o_ff[3]) << 8) - 25'(o_ff[3]);
   assign a8_in    = 8'((a_scaled + 25'd32768) >> 16);

   // binary search over the encode thresholds: upper nibble, then lower
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         nhi_in[k] = '0;
         for (int b = 7; b >= 4; b--) begin
            if (bstb_pkg::SRGB_THRESH[nhi_in[k] | (8'd1 << b)] <= o_ff[k]) begin
               nhi_in[k] = nhi_in[k] | (8'd1 << b);
            end
         end
         n_in[k] = nhi_ff[k];
         for (int b = 3; b >= 0; b--) begin
            if (bstb_pkg::SRGB_THRESH[n_in[k] | (8'd1 << b)] <= o8_ff[k]) begin
               n_in[k] = n_in[k] | (8'd1 << b);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[7:0], head_valid};
      end
   end

   // tint registers must only change while idle; the block itself does not enforce this
   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         tt_ff[k] <= 16'(tint[2-k]) * 16'(tint[bstb_pkg::CSR_TINT_ALPHA]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         top_ff  <= top_in;
         bot_ff  <= bot_in;
         wy_ff   <= head_item.weight_y[WW-1:0];
         d1_ff   <= head_item.dlin;
         tex_ff  <= tex_in;
         d2_ff   <= d1_ff;
         pa_ff   <= 25'(tex_ff[3]) * 25'(tint[bstb_pkg::CSR_TINT_ALPHA]);
         for (int k = 0; k < 3; k++) begin
            px_ff[k] <= 33'(tex_ff[k]) * 33'(tt_ff[k]);
         end
         d3_ff   <= d2_ff;
         sa_ff   <= sa_in;
         q1_ff   <= q1_in;
         d4_ff   <= d3_ff;
         src_ff  <= src_in;
         inv_ff  <= bstb_pkg::ONE_Q16 - sa_ff;
         d5_ff   <= d4_ff;
         for (int k = 0; k < 4; k++) begin
            prod_ff[k] <= 34'(d5_ff[k]) * 34'(inv_ff);
         end
         src6_ff <= src_ff;
         o_ff    <= o_in;
         nhi_ff  <= nhi_in;
         o8_ff   <= o_ff[2:0];
         a8_ff   <= a8_in;
         pixel_ff <= {a8_ff, n_in[2], n_in[1], n_in[0]};
      end
   end

`ifndef SYNTHESIS
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      vld_ff[8] && rsp_stall |=> $stable(vld_ff))
      else $error("pipeline moved while output stalled");
   a_fill: assert property (@(posedge clock) disable iff (reset)
      en |=> vld_ff[0] == $past(head_valid))
      else $error("first stage lost a queue transfer");
`endif

endmodule
`default_nettype wire

/* src/bilinear_srgb_texel_blend_unit.sv */
// Top level of the bilinear sRGB texel blend unit: tint registers and block wiring.
//
// Usage:
//  - Request channel (req_*): four AARRGGBB texels, two bilinear weights and
//    the destination pixel. A transfer happens when req_valid is high and
//    req_stall is low. Weights above one saturate to one.
//  - Response channel (rsp_*): one blended AARRGGBB pixel per request, in order.
//    A transfer happens when rsp_valid is high and rsp_stall is low.
//  - CSR port: csr_write_enable with csr_index selects tint red, green, blue
//    or alpha; csr_write_data is taken at that edge. Write only while idle.
//  - Path: a transferred request is written into the front queue; the first
//    blend stage loads it from the queue head, and the nine-stage pipeline
//    does the rest.
//  - Throughput: one pixel per clock while the response is not stalled, set by the fully pipelined blend path.
//  - A stalled response freezes the pipeline; requests keep landing in the
//    front queue until it fills, then req_stall rises.
//  - Reset (synchronous, active high) empties queue and pipeline and sets all
//    tints to 255.
`default_nettype none
module bilinear_srgb_texel_blend_unit #(
   parameter int WEIGHT_BITS = bstb_pkg::WEIGHT_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = bstb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_texel_a,
   input  wire logic [31:0] req_texel_b,
   input  wire logic [31:0] req_texel_c,
   input  wire logic [31:0] req_texel_d,
   input  wire logic [8:0]  req_weight_x,
   input  wire logic [8:0]  req_weight_y,
   input  wire logic [31:0] req_dest_pixel,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_blended_pixel,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_write_data
);

   logic [3:0][7:0]    tint_ff, tint_in;
   logic               push, pop, full, head_valid;
   bstb_pkg::item_type push_item, head_item;

   // tint registers, indexed as in the CSR map
   always_comb begin
      tint_in = tint_ff;
      if (csr_write_enable) begin
         case (bstb_pkg::csr_index_type'(csr_index))
            bstb_pkg::CSR_TINT_RED:   tint_in[bstb_pkg::CSR_TINT_RED]   = csr_write_data;
            bstb_pkg::CSR_TINT_GREEN: tint_in[bstb_pkg::CSR_TINT_GREEN] = csr_write_data;
            bstb_pkg::CSR_TINT_BLUE:  tint_in[bstb_pkg::CSR_TINT_BLUE]  = csr_write_data;
            bstb_pkg::CSR_TINT_ALPHA: tint_in[bstb_pkg::CSR_TINT_ALPHA] = csr_write_data;
            default: tint_in = tint_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tint_ff <= {4{8'hff}};
      end else begin
         tint_ff <= tint_in;
      end
   end

   // front: clamp weights, linearize every channel
   bstb_front #(.WEIGHT_BITS(WEIGHT_BITS)) u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_texel_a    (req_texel_a),
      .req_texel_b    (req_texel_b),
      .req_texel_c    (req_texel_c),
      .req_texel_d    (req_texel_d),
      .req_weight_x   (req_weight_x),
      .req_weight_y   (req_weight_y),
      .req_dest_pixel (req_dest_pixel),
      .queue_full     (full),
      .push           (push),
      .push_item      (push_item)
   );

   // decoupling queue
   bstb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .head_item  (head_item),
      .head_valid (head_valid),
      .full       (full)
   );

   // back: filter, tint, composite, encode
   bstb_back #(.WEIGHT_BITS(WEIGHT_BITS)) u_back (
      .clock             (clock),
      .reset             (reset),
      .head_item         (head_item),
      .head_valid        (head_valid),
      .head_pop          (pop),
      .tint              (tint_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_blended_pixel (rsp_blended_pixel)
   );

endmodule
`default_nettype wire

/* tb/tb_bilinear_srgb_texel_blend_unit.sv */
// Self-checking bench for the bilinear sRGB texel blend unit.
`default_nettype none
module tb_bilinear_srgb_texel_blend_unit;

   localparam int WBITS  = 8;
   localparam longint WONE = 64'd1 << WBITS;
   localparam longint ONE  = 64'd65536;

   typedef struct {
      logic [31:0] texel_a;
      logic [31:0] texel_b;
      logic [31:0] texel_c;
      logic [31:0] texel_d;
      logic [8:0]  weight_x;
      logic [8:0]  weight_y;
      logic [31:0] dest_pixel;
   } blend_req_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_texel_a, req_texel_b, req_texel_c, req_texel_d;
   logic [8:0]  req_weight_x, req_weight_y;
   logic [31:0] req_dest_pixel;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_blended_pixel;
   logic        csr_write_enable;
   bstb_pkg::csr_index_type csr_index;
   logic [7:0]  csr_write_data;

   bilinear_srgb_texel_blend_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_texel_a(req_texel_a), .req_texel_b(req_texel_b),
      .req_texel_c(req_texel_c), .req_texel_d(req_texel_d),
      .req_weight_x(req_weight_x), .req_weight_y(req_weight_y),
      .req_dest_pixel(req_dest_pixel),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_blended_pixel(rsp_blended_pixel),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // Local copy of the tint registers, reset values.
   logic [7:0] tint_r = 8'd255, tint_g = 8'd255, tint_b = 8'd255, tint_a = 8'd255;

   blend_req_type pending_reqs[$];
   logic [31:0]   expected_pixels[$];
   blend_req_type cur_req;
   int            error_count = 0;
   int            transfers_in = 0;
   int            transfers_out = 0;

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // ---------------------------------------------------------------- predictor
   function automatic longint lin_color(input longint c);
      return (c * c * 65536 + 32512) / 65025;
   endfunction

   function automatic longint lin_alpha(input longint a);
      return (a * 65536 + 127) / 255;
   endfunction

   function automatic longint clamp_one(input longint v);
      return (v > ONE) ? ONE : v;
   endfunction

   // Largest code whose lower decision point sits at or below v.
   function automatic longint encode_srgb(input longint v);
      longint n;
      longint odd;
      n = 0;
      for (int k = 1; k <= 255; k++) begin
         odd = 2 * k - 1;
         if (odd * odd * 65536 <= 260100 * v) n = k;
      end
      return n;
   endfunction

   // Bilinear sample of one channel byte at the given shift.
   function automatic longint sample_lin(input blend_req_type r, input int sh,
                                         input bit is_alpha, input longint wx,
                                         input longint wy);
      longint v[4];
      logic [31:0] px[4];
      longint top, bot;
      px[0] = r.texel_a; px[1] = r.texel_b; px[2] = r.texel_c; px[3] = r.texel_d;
      for (int i = 0; i < 4; i++) begin
         v[i] = is_alpha ? lin_alpha(longint'((px[i] >> sh) & 32'hff))
                         : lin_color(longint'((px[i] >> sh) & 32'hff));
      end
      top = v[0] * (WONE - wx) + v[1] * wx;
      bot = v[2] * (WONE - wx) + v[3] * wx;
      return (top * (WONE - wy) + bot * wy + (64'd1 << (2 * WBITS - 1))) >> (2 * WBITS);
   endfunction

   function automatic logic [31:0] predict_blend(input blend_req_type r);
      longint wx, wy, sa, inv, da, oa, s, d, o, tint;
      logic [31:0] pix;
      int sh;
      wx = (longint'(r.weight_x) > WONE) ? WONE : longint'(r.weight_x);
      wy = (longint'(r.weight_y) > WONE) ? WONE : longint'(r.weight_y);
      sa  = clamp_one((sample_lin(r, 24, 1'b1, wx, wy) * tint_a + 127) / 255);
      inv = ONE - sa;
      da  = lin_alpha(longint'(r.dest_pixel[31:24]));
      oa  = clamp_one(((da * inv + 32768) >> 16) + sa);
      pix = '0;
      pix[31:24] = 8'((255 * oa + 32768) >> 16);
      for (int ch = 0; ch < 3; ch++) begin
         sh   = 16 - 8 * ch;
         tint = (ch == 0) ? tint_r : (ch == 1) ? tint_g : tint_b;
         s = clamp_one((sample_lin(r, sh, 1'b0, wx, wy) * tint * tint_a + 32512) / 65025);
         d = lin_color(longint'((r.dest_pixel >> sh) & 32'hff));
         o = clamp_one(((d * inv + 32768) >> 16) + s);
         pix[sh +: 8] = 8'(encode_srgb(o));
      end
      return pix;
   endfunction

   // ------------------------------------------------------------------ driver
   // Bursts of random length separated by random gaps; payload held while stalled.
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      logic next_valid;
      next_valid = req_valid;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            expected_pixels.push_back(predict_blend(cur_req));
            transfers_in++;
         end
         next_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_reqs.size() > 0) begin
            cur_req = pending_reqs.pop_front();
            next_valid = 1'b1;
            req_texel_a    <= cur_req.texel_a;
            req_texel_b    <= cur_req.texel_b;
            req_texel_c    <= cur_req.texel_c;
            req_texel_d    <= cur_req.texel_d;
            req_weight_x   <= cur_req.weight_x;
            req_weight_y   <= cur_req.weight_y;
            req_dest_pixel <= cur_req.dest_pixel;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               // new burst; a third of them run back to back with no gap
               burst_left = $urandom_range(0, 40);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
      req_valid <= next_valid;
   end

   // ----------------------------------------------------------------- monitor
   // Stall pattern cycles through modes: none, light, heavy, long solid stall.
   int stall_tick = 0;

   always @(posedge clock) begin
      int mode;
      logic [31:0] want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            transfers_out++;
            if (expected_pixels.size() == 0) begin
               $error("unexpected transfer: blended_pixel actual %h", rsp_blended_pixel);
               error_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_blended_pixel !== want) begin
                  $error("blended_pixel mismatch: expected %h actual %h",
                         want, rsp_blended_pixel);
                  error_count++;
               end
            end
         end
         stall_tick++;
         mode = (stall_tick / 97) % 4;
         case (mode)
            0: begin
               rsp_stall <= 1'b0;
            end
            1: begin
               rsp_stall <= ($urandom_range(0, 9) < 3);
            end
            2: begin
               rsp_stall <= ($urandom_range(0, 9) < 7);
            end
            default: begin
               rsp_stall <= ((stall_tick % 97) < 20);
            end
         endcase
      end
   end

   // --------------------------------------------------------------- stimulus
   task automatic write_tint(input bstb_pkg::csr_index_type idx, input logic [7:0] val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      case (idx)
         bstb_pkg::CSR_TINT_RED:   tint_r = val;
         bstb_pkg::CSR_TINT_GREEN: tint_g = val;
         bstb_pkg::CSR_TINT_BLUE:  tint_b = val;
         default:                  tint_a = val;
      endcase
   endtask

   task automatic set_tints(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic [7:0] a);
      write_tint(bstb_pkg::CSR_TINT_RED, r);
      write_tint(bstb_pkg::CSR_TINT_GREEN, g);
      write_tint(bstb_pkg::CSR_TINT_BLUE, b);
      write_tint(bstb_pkg::CSR_TINT_ALPHA, a);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic queue_blend(input logic [31:0] ta, input logic [31:0] tb,
                              input logic [31:0] tc, input logic [31:0] td,
                              input logic [8:0] wx, input logic [8:0] wy,
                              input logic [31:0] dst);
      blend_req_type r;
      r.texel_a = ta; r.texel_b = tb; r.texel_c = tc; r.texel_d = td;
      r.weight_x = wx; r.weight_y = wy; r.dest_pixel = dst;
      pending_reqs.push_back(r);
   endtask

   // Texel with colour at or below alpha most of the time (well-formed
   // premultiplied data), fully random otherwise.
   function automatic logic [31:0] rand_texel();
      logic [7:0] a;
      if ($urandom_range(0, 3) == 0) return $urandom();
      a = 8'($urandom_range(0, 255));
      return {a, 8'($urandom_range(0, a)), 8'($urandom_range(0, a)),
              8'($urandom_range(0, a))};
   endfunction

   function automatic logic [8:0] rand_weight();
      case ($urandom_range(0, 9))
         0: return 9'd0;
         1: return 9'd256;
         2: return 9'($urandom_range(257, 511));
         default: return 9'($urandom_range(0, 256));
      endcase
   endfunction

   task automatic queue_random(input int count);
      for (int i = 0; i < count; i++) begin
         queue_blend(rand_texel(), rand_texel(), rand_texel(), rand_texel(),
                     rand_weight(), rand_weight(), $urandom());
      end
   endtask

   // Waits for the block to drain, then lets the pipeline settle.
   task automatic drain();
      while (pending_reqs.size() != 0 || req_valid || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      rsp_stall        = 1'b0;
      req_texel_a      = '0;
      req_texel_b      = '0;
      req_texel_c      = '0;
      req_texel_d      = '0;
      req_weight_x     = '0;
      req_weight_y     = '0;
      req_dest_pixel   = '0;
      csr_write_enable = 1'b0;
      csr_index        = bstb_pkg::CSR_TINT_RED;
      csr_write_data   = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset tints: extremes, weight saturation, colour over alpha.
      @(negedge clock);
      queue_blend('0, '0, '0, '0, 9'd0, 9'd0, '0);
      queue_blend('1, '1, '1, '1, 9'd256, 9'd256, '1);
      queue_blend('1, '0, '0, '0, 9'd0, 9'd0, 32'h80402010);
      queue_blend('0, '1, '0, '0, 9'd256, 9'd0, 32'hff000000);
      queue_blend('0, '0, '1, '0, 9'd0, 9'd256, 32'h00ffffff);
      queue_blend('0, '0, '0, '1, 9'd511, 9'd511, '0);
      queue_blend('0, '1, '1, '1, 9'd257, 9'd300, 32'h7f7f7f7f);
      queue_blend(32'h00ffffff, 32'h00ffffff, 32'h00ffffff, 32'h00ffffff,
                  9'd128, 9'd128, 32'hff123456);
      queue_blend(32'h10ff8040, 32'h20ff0000, 32'h0000ff00, 32'h000000ff,
                  9'd64, 9'd192, 32'h40aabbcc);
      queue_blend(32'hff010101, 32'hfffefefe, 32'h80808080, 32'h01010101,
                  9'd1, 9'd255, 32'h00000000);
      queue_blend(32'haaaaaaaa, 32'h55555555, 32'h55555555, 32'haaaaaaaa,
                  9'h155, 9'h0aa, 32'h5555aaaa);
      queue_blend(32'hffff0000, 32'hff00ff00, 32'hff0000ff, 32'hffffffff,
                  9'd128, 9'd256, 32'hff808080);
      drain();

      // Tints at zero: source vanishes, destination alpha still composited.
      set_tints(8'd0, 8'd0, 8'd0, 8'd0);
      @(negedge clock);
      queue_blend('1, '1, '1, '1, 9'd256, 9'd256, 32'h80ff8001);
      queue_blend('1, '0, '1, '0, 9'd128, 9'd128, '1);
      queue_random(150);
      drain();

      // Full colour, half alpha: colour easily exceeds alpha and saturates.
      set_tints(8'd255, 8'd255, 8'd255, 8'd128);
      @(negedge clock);
      queue_blend(32'h00ffffff, 32'h00ffffff, 32'h00ffffff, 32'h00ffffff,
                  9'd0, 9'd0, 32'h00ffffff);
      queue_random(150);
      drain();

      // Mixed tints, one channel dark.
      set_tints(8'd200, 8'd1, 8'd254, 8'd255);
      @(negedge clock);
      queue_random(150);
      drain();

      // Random tints over a few phases.
      for (int p = 0; p < 3; p++) begin
         set_tints(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         @(negedge clock);
         queue_random(150);
         drain();
      end

      // Back to full tints for the tail.
      set_tints(8'd255, 8'd255, 8'd255, 8'd255);
      @(negedge clock);
      queue_random(100);
      drain();

      $display("Covered %0d request and %0d response transfers over 8 tint settings,",
               transfers_in, transfers_out);
      $display("with weight saturation, zero and full tints and random stalls.");
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #5000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
`default_nettype wire

/* files.f */
src/bstb_pkg.sv
src/bstb_front.sv
src/bstb_queue.sv
src/bstb_back.sv
src/bilinear_srgb_texel_blend_unit.sv
tb/tb_bilinear_srgb_texel_blend_unit.sv
